// File: design/ffrq_pkg.sv
// shared constants, types and command/status structs of the frame fenced release queue
`timescale 1ns / 1ps
`default_nettype none
package ffrq_pkg;

    localparam int QUEUE_DEPTH = 64;

    localparam int ACTION_W  = 2;
    localparam int KIND_W    = 3;
    localparam int ID_W      = 32;
    localparam int STAMP_W   = 64;
    localparam int DELAY_W   = 4;
    localparam int PENDING_W = 7;
    localparam int ENTRY_W   = KIND_W + ID_W + STAMP_W;

    localparam logic [DELAY_W-1:0]  RETIRE_DELAY_RESET = 4'd3;
    localparam logic [KIND_W-1:0]   KIND_UNUSED        = 3'd7;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN_RD  = 5'b00010,
        S_SCAN_CHK = 5'b00100,
        S_EMIT_RD  = 5'b01000,
        S_EMIT_OUT = 5'b10000
    } t_state;

    typedef struct packed {
        logic enq;
        logic adv;
        logic flush;
        logic other;
        logic scan_rd;
        logic scan_step;
        logic scan_done;
        logic emit_rd;
        logic emit_out;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_end;
        logic scan_zero;
        logic scan_hit;
        logic emit_last;
    } t_status;

endpackage
`default_nettype wire

// File: design/ffrq_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ffrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/ffrq_ctrl.sv
// controller state machine of the frame fenced release queue
`timescale 1ns / 1ps
`default_nettype none
module ffrq_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [ffrq_pkg::ACTION_W-1:0]    i_action,
    input  wire ffrq_pkg::t_status                i_status,
    output ffrq_pkg::t_cmd                        o_cmd,
    output logic                                  o_busy
);

    ffrq_pkg::t_state r_state;
    ffrq_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ffrq_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ffrq_pkg::ACT_ENQUEUE: begin
                            o_cmd.enq = 1'b1;
                        end
                        ffrq_pkg::ACT_ADVANCE: begin
                            o_cmd.adv = 1'b1;
                            n_state   = ffrq_pkg::S_SCAN_RD;
                        end
                        ffrq_pkg::ACT_FLUSH: begin
                            o_cmd.flush = 1'b1;
                            if (!i_status.count_zero) begin
                                n_state = ffrq_pkg::S_EMIT_RD;
                            end
                        end
                        default: begin
                            o_cmd.other = 1'b1;
                        end
                    endcase
                end
            end
            ffrq_pkg::S_SCAN_RD: begin
                if (i_status.scan_end) begin
                    o_cmd.scan_done = 1'b1;
                    n_state = i_status.scan_zero ? ffrq_pkg::S_IDLE : ffrq_pkg::S_EMIT_RD;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = ffrq_pkg::S_SCAN_CHK;
                end
            end
            ffrq_pkg::S_SCAN_CHK: begin
                if (i_status.scan_hit) begin
                    o_cmd.scan_step = 1'b1;
                    n_state = ffrq_pkg::S_SCAN_RD;
                end else begin
                    o_cmd.scan_done = 1'b1;
                    n_state = i_status.scan_zero ? ffrq_pkg::S_IDLE : ffrq_pkg::S_EMIT_RD;
                end
            end
            ffrq_pkg::S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = ffrq_pkg::S_EMIT_OUT;
            end
            ffrq_pkg::S_EMIT_OUT: begin
                o_cmd.emit_out = 1'b1;
                n_state = i_status.emit_last ? ffrq_pkg::S_IDLE : ffrq_pkg::S_EMIT_RD;
            end
            default: begin
                n_state = ffrq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffrq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ffrq_pkg::S_IDLE);

endmodule
`default_nettype wire

// File: design/ffrq_datapath.sv
// queue storage, pointers, frame counter, retire test and result registers
`timescale 1ns / 1ps
`default_nettype none
module ffrq_datapath #(
    parameter int QUEUE_DEPTH = ffrq_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ffrq_pkg::t_cmd                    i_cmd,
    output ffrq_pkg::t_status                      o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [ffrq_pkg::DELAY_W-1:0]      i_cfg_wdata,
    input  wire logic [ffrq_pkg::KIND_W-1:0]       i_resource_kind,
    input  wire logic [ffrq_pkg::ID_W-1:0]         i_resource_id,
    output logic                                   o_strobe,
    output logic                                   o_release_valid,
    output logic      [ffrq_pkg::KIND_W-1:0]       o_release_kind,
    output logic      [ffrq_pkg::ID_W-1:0]         o_release_id,
    output logic                                   o_last,
    output logic      [ffrq_pkg::PENDING_W-1:0]    o_pending_count,
    output logic                                   o_overflow
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_scan_ptr, n_scan_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan_n, n_scan_n;
    logic [CNT_W-1:0] r_emit_left, n_emit_left;
    logic [CNT_W-1:0] r_final, n_final;
    logic [ffrq_pkg::STAMP_W-1:0] r_frame, n_frame;
    logic [ffrq_pkg::DELAY_W-1:0] r_delay;

    logic                              r_strobe, n_strobe;
    logic                              r_rel_valid, n_rel_valid;
    logic [ffrq_pkg::KIND_W-1:0]       r_rel_kind, n_rel_kind;
    logic [ffrq_pkg::ID_W-1:0]         r_rel_id, n_rel_id;
    logic                              r_last, n_last;
    logic [ffrq_pkg::PENDING_W-1:0]    r_pending, n_pending;
    logic                              r_overflow, n_overflow;

    logic                              ram_we;
    logic [PTR_W-1:0]                  ram_raddr;
    logic [ffrq_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [ffrq_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [ffrq_pkg::KIND_W-1:0]       rd_kind;
    logic [ffrq_pkg::ID_W-1:0]         rd_id;
    logic [ffrq_pkg::STAMP_W-1:0]      rd_stamp;
    logic [ffrq_pkg::STAMP_W-1:0]      age;
    logic                              full;
    logic                              id_ok;
    logic                              do_status;
    logic                              status_ovf;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign ram_wdata = {i_resource_kind, i_resource_id, r_frame};
    assign ram_raddr = i_cmd.emit_rd ? r_head : r_scan_ptr;
    assign {rd_kind, rd_id, rd_stamp} = ram_rdata;
    assign age   = r_frame - rd_stamp;
    assign full  = (r_count == CNT_FULL);
    assign id_ok = (i_resource_id != '0);

    ffrq_ram #(
        .WIDTH (ffrq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status.count_zero = (r_count == '0);
        o_status.scan_end   = (r_scan_n == r_count);
        o_status.scan_zero  = (r_scan_n == '0);
        o_status.scan_hit   = (age >= ffrq_pkg::STAMP_W'(r_delay));
        o_status.emit_last  = (r_emit_left == CNT_ONE);
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_scan_ptr  = r_scan_ptr;
        n_count     = r_count;
        n_scan_n    = r_scan_n;
        n_emit_left = r_emit_left;
        n_final     = r_final;
        n_frame     = r_frame;
        n_strobe    = 1'b0;
        n_rel_valid = r_rel_valid;
        n_rel_kind  = r_rel_kind;
        n_rel_id    = r_rel_id;
        n_last      = r_last;
        n_pending   = r_pending;
        n_overflow  = r_overflow;
        ram_we      = 1'b0;
        do_status   = 1'b0;
        status_ovf  = 1'b0;

        if (i_cmd.enq) begin
            do_status  = 1'b1;
            status_ovf = id_ok && full;
            if (id_ok && !full) begin
                ram_we  = 1'b1;
                n_tail  = next_slot(r_tail);
                n_count = r_count + CNT_ONE;
            end
        end
        if (i_cmd.adv) begin
            n_frame    = r_frame + ffrq_pkg::STAMP_W'(1);
            n_scan_ptr = r_head;
            n_scan_n   = '0;
        end
        if (i_cmd.flush) begin
            if (r_count == '0) begin
                do_status = 1'b1;
            end else begin
                n_emit_left = r_count;
                n_final     = '0;
            end
        end
        if (i_cmd.other) begin
            do_status = 1'b1;
        end
        if (i_cmd.scan_step) begin
            n_scan_n   = r_scan_n + CNT_ONE;
            n_scan_ptr = next_slot(r_scan_ptr);
        end
        if (i_cmd.scan_done) begin
            if (r_scan_n == '0) begin
                do_status = 1'b1;
            end else begin
                n_emit_left = r_scan_n;
                n_final     = r_count - r_scan_n;
            end
        end
        if (i_cmd.emit_out) begin
            n_strobe    = 1'b1;
            n_rel_valid = (rd_kind != ffrq_pkg::KIND_UNUSED);
            n_rel_kind  = rd_kind;
            n_rel_id    = rd_id;
            n_last      = (r_emit_left == CNT_ONE);
            n_pending   = ffrq_pkg::PENDING_W'(r_final);
            n_overflow  = 1'b0;
            n_head      = next_slot(r_head);
            n_count     = r_count - CNT_ONE;
            n_emit_left = r_emit_left - CNT_ONE;
        end
        if (do_status) begin
            n_strobe    = 1'b1;
            n_rel_valid = 1'b0;
            n_rel_kind  = '0;
            n_rel_id    = '0;
            n_last      = 1'b1;
            n_pending   = ffrq_pkg::PENDING_W'(n_count);
            n_overflow  = status_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_frame  <= '0;
            r_delay  <= ffrq_pkg::RETIRE_DELAY_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_frame  <= n_frame;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_ptr  <= n_scan_ptr;
        r_scan_n    <= n_scan_n;
        r_emit_left <= n_emit_left;
        r_final     <= n_final;
        r_rel_valid <= n_rel_valid;
        r_rel_kind  <= n_rel_kind;
        r_rel_id    <= n_rel_id;
        r_last      <= n_last;
        r_pending   <= n_pending;
        r_overflow  <= n_overflow;
    end

    assign o_strobe        = r_strobe;
    assign o_release_valid = r_rel_valid;
    assign o_release_kind  = r_rel_kind;
    assign o_release_id    = r_rel_id;
    assign o_last          = r_last;
    assign o_pending_count = r_pending;
    assign o_overflow      = r_overflow;

endmodule
`default_nettype wire

// File: design/frame_fenced_release_queue_top.sv
// top level of the frame fenced release queue
`timescale 1ns / 1ps
`default_nettype none
// Commands are taken when i_start is high and o_busy is low. An enqueue's status word
// shows on the result ports in the next cycle, with o_busy already low. An advance first
// walks the retirable head entries one by one through the registered read port of the
// entry ram, then emits them, reading each entry from the ram before it puts out its word;
// a flush emits every queued entry in the same way. Every word is valid for one cycle
// only while o_strobe is high and cannot be stalled; each command ends with a word that
// has o_last set, and a command that releases nothing gives a single status word.
// o_pending_count is the queue fill after the whole command.
// The retire delay register may only be written while o_busy is low.
module frame_fenced_release_queue_top #(
    parameter int QUEUE_DEPTH = ffrq_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [ffrq_pkg::ACTION_W-1:0]     i_action,
    input  wire logic [ffrq_pkg::KIND_W-1:0]       i_resource_kind,
    input  wire logic [ffrq_pkg::ID_W-1:0]         i_resource_id,
    input  wire logic                              i_cfg_we,
    input  wire logic [ffrq_pkg::DELAY_W-1:0]      i_cfg_wdata,
    output logic                                   o_strobe,
    output logic                                   o_release_valid,
    output logic      [ffrq_pkg::KIND_W-1:0]       o_release_kind,
    output logic      [ffrq_pkg::ID_W-1:0]         o_release_id,
    output logic                                   o_last,
    output logic      [ffrq_pkg::PENDING_W-1:0]    o_pending_count,
    output logic                                   o_overflow
);

    ffrq_pkg::t_cmd    cmd;
    ffrq_pkg::t_status status;

    ffrq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    ffrq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_resource_kind (i_resource_kind),
        .i_resource_id   (i_resource_id),
        .o_strobe        (o_strobe),
        .o_release_valid (o_release_valid),
        .o_release_kind  (o_release_kind),
        .o_release_id    (o_release_id),
        .o_last          (o_last),
        .o_pending_count (o_pending_count),
        .o_overflow      (o_overflow)
    );

endmodule
`default_nettype wire

// File: design/ffrq_checker.sv
// port level checker of the frame fenced release queue and its bind
`timescale 1ns / 1ps
`default_nettype none
module ffrq_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_start,
    input wire logic                              o_busy,
    input wire logic [ffrq_pkg::ACTION_W-1:0]     i_action,
    input wire logic                              o_strobe,
    input wire logic                              o_release_valid,
    input wire logic                              o_last,
    input wire logic                              o_overflow
);

    // an overflow word is always a lone status word
    a_ovf_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_overflow |-> !o_release_valid && o_last)
        else $error("overflow on a release word");

    // an enqueue answers with its final word in the next cycle
    a_enq_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_action == ffrq_pkg::ACT_ENQUEUE |=> o_strobe && o_last)
        else $error("enqueue word missing");

    // more words of a command pending keeps the block busy
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_busy)
        else $error("not busy while a command still emits");

    // a release word that is not the last is never directly followed by another word
    a_word_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> !o_strobe)
        else $error("release words back to back");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !o_busy)
        else $error("activity right after reset");

endmodule

bind frame_fenced_release_queue_top ffrq_checker u_ffrq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_action        (i_action),
    .o_strobe        (o_strobe),
    .o_release_valid (o_release_valid),
    .o_last          (o_last),
    .o_overflow      (o_overflow)
);
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench of the frame fenced release queue: predictor scoreboard and drivers
`timescale 1ns / 1ps
module tb_top;
    import ffrq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 27;
    localparam int PHASE_COUNT   = 6;
    localparam int FILL_ITEMS    = QUEUE_DEPTH + 3;

    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [ID_W-1:0]      id;
        logic                 last;
        logic [PENDING_W-1:0] pending;
        logic                 overflow;
    } t_release_word;

    class t_release_scoreboard;
        logic [KIND_W-1:0]  slot_kind  [QUEUE_DEPTH];
        logic [ID_W-1:0]    slot_id    [QUEUE_DEPTH];
        logic [STAMP_W-1:0] slot_stamp [QUEUE_DEPTH];
        int                 head;
        int                 tail;
        int                 fill;
        logic [STAMP_W-1:0] frame_no;
        logic [DELAY_W-1:0] delay;
        t_release_word      expected_words[$];
        int                 errors;

        function new();
            head     = 0;
            tail     = 0;
            fill     = 0;
            frame_no = '0;
            delay    = RETIRE_DELAY_RESET;
            errors   = 0;
        endfunction

        function void set_delay(logic [DELAY_W-1:0] value);
            delay = value;
        endfunction

        function t_release_word release_oldest();
            t_release_word w;
            w       = '0;
            w.kind  = slot_kind[head];
            w.valid = (slot_kind[head] != KIND_UNUSED);
            w.id    = slot_id[head];
            head    = (head + 1) % QUEUE_DEPTH;
            fill    = fill - 1;
            return w;
        endfunction

        function void note_command(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
                                   logic [ID_W-1:0] id);
            t_release_word batch[$];
            t_release_word w;
            logic          dropped;
            dropped = 1'b0;
            case (act)
                ACT_ENQUEUE: begin
                    if (id != '0) begin
                        if (fill >= QUEUE_DEPTH) begin
                            dropped = 1'b1;
                        end else begin
                            slot_kind[tail]  = kind;
                            slot_id[tail]    = id;
                            slot_stamp[tail] = frame_no;
                            tail = (tail + 1) % QUEUE_DEPTH;
                            fill = fill + 1;
                        end
                    end
                end
                ACT_ADVANCE: begin
                    frame_no = frame_no + 1;
                    while (fill > 0 && (frame_no - slot_stamp[head]) >= STAMP_W'(delay))
                        batch.insert(batch.size(), release_oldest());
                end
                ACT_FLUSH: begin
                    while (fill > 0)
                        batch.insert(batch.size(), release_oldest());
                end
                default: ;
            endcase
            if (batch.size() == 0) begin
                w          = '0;
                w.overflow = dropped;
                batch.insert(0, w);
            end
            foreach (batch[k]) begin
                batch[k].pending = PENDING_W'(fill);
                batch[k].last    = (k == batch.size() - 1);
                expected_words.insert(expected_words.size(), batch[k]);
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_word(t_release_word got);
            t_release_word want;
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing pending", 64'(got), 64'd0);
                return;
            end
            want = expected_words.pop_front();
            if (got.valid != want.valid)
                report_mismatch("release_valid", 64'(got.valid), 64'(want.valid));
            if (got.kind != want.kind)
                report_mismatch("release_kind", 64'(got.kind), 64'(want.kind));
            if (got.id != want.id)
                report_mismatch("release_id", 64'(got.id), 64'(want.id));
            if (got.last != want.last)
                report_mismatch("last", 64'(got.last), 64'(want.last));
            if (got.pending != want.pending)
                report_mismatch("pending_count", 64'(got.pending), 64'(want.pending));
            if (got.overflow != want.overflow)
                report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
        endtask

        task close_out();
            if (expected_words.size() != 0)
                report_mismatch("words never seen", 64'(expected_words.size()), 64'd0);
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    logic [ACTION_W-1:0]     i_action;
    logic [KIND_W-1:0]       i_resource_kind;
    logic [ID_W-1:0]         i_resource_id;
    logic                    i_cfg_we;
    logic [DELAY_W-1:0]      i_cfg_wdata;
    logic                    o_strobe;
    logic                    o_release_valid;
    logic [KIND_W-1:0]       o_release_kind;
    logic [ID_W-1:0]         o_release_id;
    logic                    o_last;
    logic [PENDING_W-1:0]    o_pending_count;
    logic                    o_overflow;

    t_release_scoreboard sb;
    t_release_word       seen_word;
    int                  idle_pct;
    int                  cycle_count = 0;

    frame_fenced_release_queue_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_resource_kind (i_resource_kind),
        .i_resource_id   (i_resource_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_release_valid (o_release_valid),
        .o_release_kind  (o_release_kind),
        .o_release_id    (o_release_id),
        .o_last          (o_last),
        .o_pending_count (o_pending_count),
        .o_overflow      (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                seen_word.valid    = o_release_valid;
                seen_word.kind     = o_release_kind;
                seen_word.id       = o_release_id;
                seen_word.last     = o_last;
                seen_word.pending  = o_pending_count;
                seen_word.overflow = o_overflow;
                sb.check_word(seen_word);
            end
            if (i_start && !o_busy)
                sb.note_command(i_action, i_resource_kind, i_resource_id);
        end
    end

    task automatic issue(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
                         logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start         <= 1'b1;
        i_action        <= act;
        i_resource_kind <= kind;
        i_resource_id   <= id;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_words.size() != 0 || o_busy)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_delay(logic [DELAY_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_delay(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_command();
        int                r;
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        r    = $urandom_range(0, 99);
        kind = KIND_W'($urandom_range(0, 7));
        id   = ($urandom_range(0, 99) < 6) ? '0 : ID_W'($urandom);
        if (r < 55)
            issue(ACT_ENQUEUE, kind, id);
        else if (r < 93)
            issue(ACT_ADVANCE, kind, id);
        else if (r < 97)
            issue(ACT_FLUSH, kind, id);
        else
            issue(ACT_NONE, kind, id);
    endtask

    // empty, overfill (with one zero id while full), then release everything at once
    task automatic fill_queue(logic [ACTION_W-1:0] closing);
        logic [ID_W-1:0] id;
        issue(ACT_FLUSH, '0, '0);
        for (int i = 0; i < FILL_ITEMS; i++) begin
            id = ID_W'($urandom);
            if (id == '0)
                id = 1;
            if (i == QUEUE_DEPTH + 1)
                id = '0;
            issue(ACT_ENQUEUE, KIND_W'($urandom_range(0, 7)), id);
        end
        issue(closing, '0, '0);
    endtask

    initial begin
        logic [DELAY_W-1:0] phase_delay;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_action        = ACT_ENQUEUE;
        i_resource_kind = '0;
        i_resource_id   = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        idle_pct        = 9;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset delay of three frames
        issue(ACT_ENQUEUE, 3'd0, 32'h0000_0001);
        issue(ACT_ENQUEUE, 3'd1, 32'hFFFF_FFFF);
        issue(ACT_ENQUEUE, KIND_UNUSED, 32'h8000_0000);
        issue(ACT_ENQUEUE, 3'd2, 32'h0000_0000);
        issue(ACT_NONE, 3'd5, 32'h1234_5678);
        issue(ACT_ADVANCE, 3'd0, 32'h0);
        issue(ACT_ENQUEUE, 3'd3, 32'h5555_5555);
        issue(ACT_ADVANCE, 3'd0, 32'h0);
        issue(ACT_ADVANCE, 3'd7, 32'hFFFF_FFFF);
        issue(ACT_ENQUEUE, 3'd4, 32'hAAAA_AAAA);
        issue(ACT_ENQUEUE, 3'd5, 32'h7FFF_FFFE);
        issue(ACT_ENQUEUE, 3'd6, 32'h0000_0002);
        issue(ACT_FLUSH, 3'd0, 32'h0);
        issue(ACT_FLUSH, 3'd0, 32'h0);
        issue(ACT_ADVANCE, 3'd0, 32'h0);
        issue(ACT_NONE, KIND_UNUSED, 32'hFFFF_FFFF);
        issue(ACT_ENQUEUE, KIND_UNUSED, 32'hFFFF_FFFF);
        issue(ACT_ADVANCE, 3'd0, 32'h0);
        quiesce();

        // zero delay retires at the very next advance
        write_delay(4'd0);
        issue(ACT_ENQUEUE, 3'd6, 32'hDEAD_BEEF);
        issue(ACT_ENQUEUE, 3'd0, 32'h0000_0003);
        issue(ACT_ADVANCE, 3'd0, 32'h0);
        issue(ACT_ADVANCE, 3'd0, 32'h0);
        quiesce();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: phase_delay = 4'd1;
                1: phase_delay = 4'd15;
                2: phase_delay = 4'd0;
                default: phase_delay = DELAY_W'($urandom_range(0, 15));
            endcase
            idle_pct = (p < 2) ? 9 : (p < 4) ? 62 : 0;
            write_delay(phase_delay);
            if (p == 1)
                fill_queue(ACT_FLUSH);
            if (p == 2)
                fill_queue(ACT_ADVANCE);
            repeat (PHASE_ITEMS) random_command();
            quiesce();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: files.f
design/ffrq_pkg.sv
design/ffrq_ram.sv
design/ffrq_ctrl.sv
design/ffrq_datapath.sv
design/frame_fenced_release_queue_top.sv
design/ffrq_checker.sv
tb/tb_top.sv
